/* sv/fefd_pkg.sv */
`default_nettype none

package fefd_pkg;

    localparam int TIME_W = 30;
    localparam int CFG_W = 7;
    localparam int VEH_OUT_W = 6;
    localparam int OUT_FIELDS_W = 1 + VEH_OUT_W + TIME_W + 1 + TIME_W;
    localparam int OUT_W = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam logic [TIME_W-1:0] NO_FINISH = 30'd1000000000;
    localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

    typedef struct packed {
        logic clear;
        logic valid;
    } t_eval_ctl;

    typedef struct packed {
        logic [TIME_W-1:0] fin;
        logic [TIME_W-1:0] idle;
        logic              early;
    } t_best;

endpackage

`default_nettype wire

/* sv/fleet_earliest_finish_dispatch.sv */
// Greedy earliest-finish dispatcher. Each job request is scored against every vehicle in
// use, one vehicle per cycle. Vehicles are read through the one read port of the vehicle
// memory into an evaluation pipeline that keeps the best finish so far. A job is scored
// alone: vehicles_in_use is capped at MAX_VEHICLES, and the next job is taken only after
// the result of the last one is loaded and the block has returned to idle. A result that
// waits on the output holds the block until it is taken. After reset a clearing pass
// zeroes the vehicle memory before the first job is taken; configuration writes are taken
// at any time and should be issued only while idle.
`default_nettype none

module fleet_earliest_finish_dispatch #(
    parameter int MAX_VEHICLES = 64,
    parameter int COORD_BITS = 16
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_cfg_valid,
    output logic                                        o_cfg_ready,
    input  wire logic [fefd_pkg::CFG_W-1:0]             i_cfg_data,
    input  wire logic                                   i_s_tvalid,
    output logic                                        o_s_tready,
    // pickup_row, pickup_col, dropoff_row, dropoff_col, earliest_start, latest_finish
    input  wire logic [((4*COORD_BITS+2*fefd_pkg::TIME_W+7)/8)*8-1:0] i_s_tdata,
    output logic                                        o_m_tvalid,
    input  wire logic                                   i_m_tready,
    // accepted, chosen_vehicle, best finish, on_time, wait_time
    output logic [fefd_pkg::OUT_W-1:0]                  o_m_tdata
);

    localparam int CB = COORD_BITS;
    localparam int TW = fefd_pkg::TIME_W;
    localparam int VW = (MAX_VEHICLES > 1) ? $clog2(MAX_VEHICLES) : 1;
    localparam int CW = $clog2(MAX_VEHICLES + 1);
    localparam int CMW = (CW > fefd_pkg::CFG_W) ? CW : fefd_pkg::CFG_W;
    localparam int MW = TW + 2 * CB;
    localparam int PAD_W = fefd_pkg::OUT_W - fefd_pkg::OUT_FIELDS_W;

    typedef enum logic [4:0] {
        S_CLEAR  = 5'b00001,
        S_IDLE   = 5'b00010,
        S_SCAN   = 5'b00100,
        S_DRAIN  = 5'b01000,
        S_DECIDE = 5'b10000
    } t_state;

    t_state                   r_state, n_state;
    logic [CW-1:0]            r_idx, n_idx;
    logic [CW-1:0]            r_cnt;
    logic [fefd_pkg::CFG_W-1:0] r_cfg;
    logic [CB-1:0]            r_pr, r_pc, r_dr, r_dc;
    logic [TW-1:0]            r_start, r_latest;
    logic [CB+1:0]            r_drive;
    logic                     r_va;
    logic [VW-1:0]            r_ia;
    logic [MW-1:0]            r_q;
    logic [MW-1:0]            r_mem [MAX_VEHICLES];
    logic                     r_out_valid;
    logic [fefd_pkg::OUT_W-1:0] r_out_data;

    logic                     w_take;
    logic                     w_issue;
    logic                     w_busy;
    logic                     w_eval_busy;
    logic                     w_out_free;
    logic                     w_acc;
    logic                     w_mem_we;
    logic [VW-1:0]            w_mem_addr;
    logic [MW-1:0]            w_mem_wdata;
    logic [CW-1:0]            w_cnt;
    logic [CB-1:0]            w_ad_r, w_ad_c;
    fefd_pkg::t_eval_ctl      w_ctl;
    fefd_pkg::t_best          w_best;
    logic [VW-1:0]            w_best_idx;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready = (r_state == S_IDLE);
    assign w_take = i_s_tvalid && (r_state == S_IDLE);
    assign w_issue = (r_state == S_SCAN) && (r_idx < r_cnt);
    assign w_busy = r_va || w_eval_busy;
    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_acc = (w_best.fin < r_latest);

    assign w_cnt = (CMW'(r_cfg) > CMW'(MAX_VEHICLES)) ? CW'(MAX_VEHICLES) : CW'(r_cfg);

    assign w_ad_r = (r_pr > r_dr) ? (r_pr - r_dr) : (r_dr - r_pr);
    assign w_ad_c = (r_pc > r_dc) ? (r_pc - r_dc) : (r_dc - r_pc);

    always_comb begin
        n_state = r_state;
        n_idx = r_idx;
        case (r_state)
            S_CLEAR: begin
                if (r_idx == CW'(MAX_VEHICLES - 1)) begin
                    n_state = S_IDLE;
                    n_idx = '0;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = S_SCAN;
                    n_idx = '0;
                end
            end
            S_SCAN: begin
                if (w_issue) begin
                    n_idx = r_idx + 1'b1;
                end else begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!w_busy) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
                n_idx = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_idx <= '0;
            r_cfg <= fefd_pkg::CFG_RESET;
            r_va <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx <= n_idx;
            r_va <= w_issue;
            if (i_cfg_valid) begin
                r_cfg <= i_cfg_data;
            end
            if ((r_state == S_DECIDE) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_pr     <= i_s_tdata[CB-1:0];
            r_pc     <= i_s_tdata[2*CB-1:CB];
            r_dr     <= i_s_tdata[3*CB-1:2*CB];
            r_dc     <= i_s_tdata[4*CB-1:3*CB];
            r_start  <= i_s_tdata[4*CB+TW-1:4*CB];
            r_latest <= i_s_tdata[4*CB+2*TW-1:4*CB+TW];
            r_cnt    <= w_cnt;
        end
        r_drive <= (CB+2)'(w_ad_r) + (CB+2)'(w_ad_c);
        r_ia <= r_idx[VW-1:0];
        if ((r_state == S_DECIDE) && w_out_free) begin
            r_out_data <= {{PAD_W{1'b0}},
                           w_acc ? w_best.idle : {TW{1'b0}},
                           w_acc && w_best.early,
                           w_best.fin,
                           w_acc ? fefd_pkg::VEH_OUT_W'(w_best_idx)
                                 : {fefd_pkg::VEH_OUT_W{1'b0}},
                           w_acc};
        end
    end

    assign w_mem_we = (r_state == S_CLEAR) ||
                      ((r_state == S_DECIDE) && w_out_free && w_acc);
    assign w_mem_addr = (r_state == S_CLEAR) ? r_idx[VW-1:0] : w_best_idx;
    assign w_mem_wdata = (r_state == S_CLEAR) ? {MW{1'b0}} : {w_best.fin, r_dr, r_dc};

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_mem_addr] <= w_mem_wdata;
        end
        r_q <= r_mem[r_idx[VW-1:0]];
    end

    assign w_ctl.clear = w_take;
    assign w_ctl.valid = r_va;

    fefd_eval #(
        .COORD_BITS(CB),
        .IDX_W(VW)
    ) u_eval (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_ctl),
        .i_idx     (r_ia),
        .i_rdy     (r_q[MW-1:2*CB]),
        .i_row     (r_q[2*CB-1:CB]),
        .i_col     (r_q[CB-1:0]),
        .i_pr      (r_pr),
        .i_pc      (r_pc),
        .i_start   (r_start),
        .i_latest  (r_latest),
        .i_drive   (r_drive),
        .o_busy    (w_eval_busy),
        .o_best    (w_best),
        .o_best_idx(w_best_idx)
    );

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata = r_out_data;

endmodule

`default_nettype wire

/* sv/fefd_eval.sv */
`default_nettype none

module fefd_eval #(
    parameter int COORD_BITS = 16,
    parameter int IDX_W = 6
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire fefd_pkg::t_eval_ctl           i_ctl,
    input  wire logic [IDX_W-1:0]              i_idx,
    input  wire logic [fefd_pkg::TIME_W-1:0]   i_rdy,
    input  wire logic [COORD_BITS-1:0]         i_row,
    input  wire logic [COORD_BITS-1:0]         i_col,
    input  wire logic [COORD_BITS-1:0]         i_pr,
    input  wire logic [COORD_BITS-1:0]         i_pc,
    input  wire logic [fefd_pkg::TIME_W-1:0]   i_start,
    input  wire logic [fefd_pkg::TIME_W-1:0]   i_latest,
    input  wire logic [COORD_BITS+1:0]         i_drive,
    output logic                               o_busy,
    output fefd_pkg::t_best                    o_best,
    output logic [IDX_W-1:0]                   o_best_idx
);

    localparam int CB = COORD_BITS;
    localparam int TW = fefd_pkg::TIME_W;

    logic [CB-1:0]   w_ad_r;
    logic [CB-1:0]   w_ad_c;
    logic            w_early;
    logic [TW+1:0]   w_fin;
    logic            w_feas;
    logic            w_better;

    logic            r_vb, r_vc, r_vd, r_ve;
    logic [IDX_W-1:0] r_ib, r_ic, r_id, r_ie;
    logic [CB:0]     r_dist_b;
    logic [TW-1:0]   r_rdy_b;
    logic [TW:0]     r_arr_c;
    logic [TW:0]     r_arr_d;
    logic [TW-1:0]   r_idle_d;
    logic            r_early_d;
    logic [TW-1:0]   r_fin_e;
    logic [TW-1:0]   r_idle_e;
    logic            r_early_e;
    fefd_pkg::t_best r_best;
    logic [IDX_W-1:0] r_best_idx;

    assign w_ad_r = (i_row > i_pr) ? (i_row - i_pr) : (i_pr - i_row);
    assign w_ad_c = (i_col > i_pc) ? (i_col - i_pc) : (i_pc - i_col);
    assign w_early = (r_arr_c <= (TW+1)'(i_start));
    assign w_fin = (TW+2)'(r_arr_d) + (TW+2)'(i_drive);
    assign w_feas = (w_fin <= (TW+2)'(i_latest));
    assign w_better = (r_fin_e < r_best.fin) ||
                      ((r_fin_e == r_best.fin) && (r_idle_e < r_best.idle));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            r_vd <= 1'b0;
            r_ve <= 1'b0;
        end else begin
            r_vb <= i_ctl.valid;
            r_vc <= r_vb;
            r_vd <= r_vc;
            r_ve <= r_vd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ib     <= i_idx;
        r_rdy_b  <= i_rdy;
        r_dist_b <= (CB+1)'(w_ad_r) + (CB+1)'(w_ad_c);

        r_ic    <= r_ib;
        r_arr_c <= (TW+1)'(r_rdy_b) + (TW+1)'(r_dist_b);

        r_id      <= r_ic;
        r_early_d <= w_early;
        r_idle_d  <= w_early ? TW'((TW+1)'(i_start) - r_arr_c) : '0;
        r_arr_d   <= w_early ? (TW+1)'(i_start) : r_arr_c;

        r_ie      <= r_id;
        r_fin_e   <= w_feas ? TW'(w_fin) : fefd_pkg::NO_FINISH;
        r_idle_e  <= r_idle_d;
        r_early_e <= r_early_d;

        if (i_ctl.clear) begin
            r_best.fin   <= fefd_pkg::NO_FINISH;
            r_best.idle  <= fefd_pkg::NO_FINISH;
            r_best.early <= 1'b0;
            r_best_idx   <= '0;
        end else if (r_ve && w_better) begin
            r_best.fin   <= r_fin_e;
            r_best.idle  <= r_idle_e;
            r_best.early <= r_early_e;
            r_best_idx   <= r_ie;
        end
    end

    assign o_busy = r_vb | r_vc | r_vd | r_ve;
    assign o_best = r_best;
    assign o_best_idx = r_best_idx;

endmodule

`default_nettype wire

/* sv/fefd_checker.sv */
`default_nettype none

module fefd_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_s_tvalid,
    input wire logic                          o_s_tready,
    input wire logic                          o_m_tvalid,
    input wire logic                          i_m_tready,
    input wire logic [fefd_pkg::OUT_W-1:0]    o_m_tdata
);

    localparam int VO = fefd_pkg::VEH_OUT_W;
    localparam int TW = fefd_pkg::TIME_W;
    localparam int ON_BIT = 1 + VO + TW;

    logic             w_acc;
    logic [VO-1:0]    w_veh;
    logic             w_on_time;
    logic [TW-1:0]    w_wait;

    assign w_acc = o_m_tdata[0];
    assign w_veh = o_m_tdata[VO:1];
    assign w_on_time = o_m_tdata[ON_BIT];
    assign w_wait = o_m_tdata[ON_BIT+TW:ON_BIT+1];

    // A job is worked on alone, so taking one closes the input until it is done.
    a_one_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("input stayed open after a job was taken");

    a_reject_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !w_acc |-> (w_veh == '0) && !w_on_time && (w_wait == '0))
        else $error("rejected job carries vehicle, on-time or wait data");

    a_on_time_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && w_on_time |-> w_acc)
        else $error("on-time flag set on a rejected job");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled result changed or dropped");

endmodule

bind fleet_earliest_finish_dispatch fefd_checker u_fefd_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

`default_nettype wire

/* tb/fleet_earliest_finish_dispatch_tb.sv */
`timescale 1ns / 1ps

module fleet_earliest_finish_dispatch_tb;

    localparam int TIME_W = fefd_pkg::TIME_W;
    localparam int CFG_W = fefd_pkg::CFG_W;
    localparam int VEH_OUT_W = fefd_pkg::VEH_OUT_W;
    localparam int OUT_W = fefd_pkg::OUT_W;
    localparam int OUT_FIELDS_W = fefd_pkg::OUT_FIELDS_W;
    localparam int MAX_VEHICLES = 64;
    localparam int COORD_BITS = 16;
    localparam int IN_FIELDS_W = 4 * COORD_BITS + 2 * TIME_W;
    localparam int IN_W = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int SETTLE_CYCLES = 2 * MAX_VEHICLES + 20;
    localparam int NUM_PHASES = 9;
    localparam longint unsigned TIME_TOP = (64'd1 << TIME_W) - 1;

    typedef struct packed {
        logic [IN_W-IN_FIELDS_W-1:0] pad;
        logic [TIME_W-1:0]           latest;
        logic [TIME_W-1:0]           start;
        logic [COORD_BITS-1:0]       drop_col;
        logic [COORD_BITS-1:0]       drop_row;
        logic [COORD_BITS-1:0]       pick_col;
        logic [COORD_BITS-1:0]       pick_row;
    } t_job;

    typedef struct packed {
        logic [OUT_W-OUT_FIELDS_W-1:0] pad;
        logic [TIME_W-1:0]             idle;
        logic                          on_time;
        logic [TIME_W-1:0]             finish;
        logic [VEH_OUT_W-1:0]          vehicle;
        logic                          accepted;
    } t_dispatch;

    class dispatch_scoreboard;
        logic [CFG_W-1:0]      vehicle_count;
        logic [TIME_W-1:0]     ready_at[MAX_VEHICLES];
        logic [COORD_BITS-1:0] row_at[MAX_VEHICLES];
        logic [COORD_BITS-1:0] col_at[MAX_VEHICLES];
        t_dispatch             expected_q[$];
        int unsigned           jobs_seen;
        int unsigned           jobs_taken;
        int unsigned           mismatches;

        function new();
            vehicle_count = fefd_pkg::CFG_RESET;
            for (int v = 0; v < MAX_VEHICLES; v++) begin
                ready_at[v] = '0;
                row_at[v] = '0;
                col_at[v] = '0;
            end
            jobs_seen = 0;
            jobs_taken = 0;
            mismatches = 0;
        endfunction

        function longint unsigned coord_dist(input logic [COORD_BITS-1:0] a,
                                             input logic [COORD_BITS-1:0] b);
            return 64'((a > b) ? a - b : b - a);
        endfunction

        function int unsigned scanned();
            return (vehicle_count > MAX_VEHICLES) ? MAX_VEHICLES : 32'(vehicle_count);
        endfunction

        function longint unsigned earliest_ready();
            longint unsigned low_mark;
            low_mark = (scanned() == 0) ? 0 : TIME_TOP;
            for (int v = 0; v < scanned(); v++)
                if (64'(ready_at[v]) < low_mark) low_mark = 64'(ready_at[v]);
            return low_mark;
        endfunction

        function void set_vehicle_count(input logic [CFG_W-1:0] n);
            vehicle_count = n;
        endfunction

        function void note_job(input t_job j);
            longint unsigned drive, arrive, idle, fin, best_fin, best_idle;
            int unsigned     best_v;
            bit              early, best_early, take;
            t_dispatch       r;
            drive = coord_dist(j.pick_row, j.drop_row) + coord_dist(j.pick_col, j.drop_col);
            best_fin = 64'(fefd_pkg::NO_FINISH);
            best_idle = 64'(fefd_pkg::NO_FINISH);
            best_v = 0;
            best_early = 1'b0;
            for (int v = 0; v < scanned(); v++) begin
                arrive = 64'(ready_at[v]) + coord_dist(row_at[v], j.pick_row)
                         + coord_dist(col_at[v], j.pick_col);
                idle = 0;
                early = 1'b0;
                if (arrive <= 64'(j.start)) begin
                    idle = 64'(j.start) - arrive;
                    arrive = 64'(j.start);
                    early = 1'b1;
                end
                fin = arrive + drive;
                if (fin > 64'(j.latest)) fin = 64'(fefd_pkg::NO_FINISH);
                if (fin < best_fin || (fin == best_fin && idle < best_idle)) begin
                    best_fin = fin;
                    best_idle = idle;
                    best_v = v;
                    best_early = early;
                end
            end
            take = best_fin < 64'(j.latest);
            if (take) begin
                ready_at[best_v] = best_fin[TIME_W-1:0];
                row_at[best_v] = j.drop_row;
                col_at[best_v] = j.drop_col;
                jobs_taken++;
            end
            r = '0;
            r.accepted = take;
            r.vehicle = take ? best_v[VEH_OUT_W-1:0] : '0;
            r.finish = best_fin[TIME_W-1:0];
            r.on_time = take && best_early;
            r.idle = take ? best_idle[TIME_W-1:0] : '0;
            expected_q = {expected_q, r};
            jobs_seen++;
        endfunction

        function void check_result(input logic [OUT_W-1:0] raw);
            t_dispatch got, want;
            got = raw;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result %h arrived with no job outstanding", $realtime, raw);
                return;
            end
            want = expected_q.pop_front();
            if (got.accepted !== want.accepted || got.vehicle !== want.vehicle
                    || got.finish !== want.finish || got.on_time !== want.on_time
                    || got.idle !== want.idle) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: expected acc=%0d veh=%0d finish=%0d on_time=%0d wait=%0d",
                             $realtime, want.accepted, want.vehicle, want.finish,
                             want.on_time, want.idle);
                    $display("%0t:      got acc=%0d veh=%0d finish=%0d on_time=%0d wait=%0d",
                             $realtime, got.accepted, got.vehicle, got.finish,
                             got.on_time, got.idle);
                end
            end
        endfunction
    endclass

    logic             i_clk;
    logic             i_rst_n = 1'b0;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    logic [CFG_W-1:0] i_cfg_data = '0;
    logic             i_s_tvalid = 1'b0;
    logic             o_s_tready;
    logic [IN_W-1:0]  i_s_tdata = '0;
    logic             o_m_tvalid;
    logic             i_m_tready = 1'b0;
    logic [OUT_W-1:0] o_m_tdata;

    dispatch_scoreboard sb = new();
    int unsigned        tx_idle_pct = 19;
    int unsigned        rx_idle_pct = 80;
    int unsigned        cycle_count = 0;
    longint unsigned    job_clock = 0;
    int unsigned        phase_counts[NUM_PHASES] = '{1, 64, 0, 127, 13, 2, 65, 40, 64};

    fleet_earliest_finish_dispatch #(
        .MAX_VEHICLES(MAX_VEHICLES),
        .COORD_BITS  (COORD_BITS)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles.", CYCLE_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) sb.check_result(o_m_tdata);
    end

    task automatic send_job(input t_job job);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= job;
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_job(job);
    endtask

    task automatic write_vehicle_count(input logic [CFG_W-1:0] n);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= n;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sb.set_vehicle_count(n);
    endtask

    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic t_job make_job(input int unsigned pr, input int unsigned pc,
                                      input int unsigned dr, input int unsigned dc,
                                      input int unsigned start, input int unsigned latest);
        t_job j;
        j = '0;
        j.pick_row = COORD_BITS'(pr);
        j.pick_col = COORD_BITS'(pc);
        j.drop_row = COORD_BITS'(dr);
        j.drop_col = COORD_BITS'(dc);
        j.start = TIME_W'(start);
        j.latest = TIME_W'(latest);
        return j;
    endfunction

    // Most jobs follow a rising time line around the fleet's ready times so that
    // vehicles stay busy and compete; the rest is noise or out-of-order windows.
    function automatic t_job random_job();
        t_job            j;
        int unsigned     kind, span;
        longint unsigned drive, base, start, lat;
        j = '0;
        kind = $urandom_range(99);
        if (kind < 12) begin
            j.pick_row = COORD_BITS'($urandom);
            j.pick_col = COORD_BITS'($urandom);
            j.drop_row = COORD_BITS'($urandom);
            j.drop_col = COORD_BITS'($urandom);
            j.start = TIME_W'($urandom);
            j.latest = TIME_W'($urandom);
            return j;
        end
        span = ($urandom_range(4) == 0) ? 16'hFFFF : 63;
        j.pick_row = COORD_BITS'($urandom_range(span));
        j.pick_col = COORD_BITS'($urandom_range(span));
        j.drop_row = COORD_BITS'($urandom_range(span));
        j.drop_col = COORD_BITS'($urandom_range(span));
        base = sb.earliest_ready();
        if (base > job_clock + 5000) job_clock = base;
        if (job_clock > TIME_TOP - 400000) job_clock = TIME_TOP - 400000;
        job_clock += 64'($urandom_range(20));
        start = job_clock + 64'($urandom_range(50));
        drive = sb.coord_dist(j.pick_row, j.drop_row) + sb.coord_dist(j.pick_col, j.drop_col);
        case ($urandom_range(3))
            0: lat = start + drive;
            1, 2: lat = start + drive + 64'($urandom_range(200, 1));
            default: lat = start + drive + 64'($urandom_range(5000, 200));
        endcase
        if (lat > TIME_TOP) lat = TIME_TOP;
        if (kind < 24) begin
            if ($urandom_range(1) == 1) start = 64'($urandom_range(32'(start)));
            else lat = 64'($urandom_range(32'(start)));
        end
        j.start = TIME_W'(start);
        j.latest = TIME_W'(lat);
        return j;
    endfunction

    task automatic run_directed();
        send_job(make_job(0, 0, 0, 0, 0, 0));
        send_job(make_job(3, 4, 10, 10, 20, 100));
        send_job(make_job(3, 4, 10, 10, 20, 100));
        send_job(make_job(0, 0, 5, 0, 100, 105));
        send_job(make_job(0, 0, 5, 0, 100, 106));
        send_job(make_job(1, 1, 2, 2, 0, 0));
        send_job(make_job(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 32'(TIME_TOP)));
        send_job(make_job(0, 0, 0, 0, 32'(TIME_TOP), 32'(TIME_TOP)));
        send_job(make_job(7, 7, 7, 7, 999999999, 999999999));
        send_job(make_job(7, 7, 7, 7, 999999998, 999999999));
        send_job(make_job(16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA, 30'h2AAAAAAA, 30'h15555555));
        send_job(make_job(16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555, 30'h15555555, 30'h2AAAAAAA));
        send_job(make_job(50, 50, 60, 60, 0, 1000));
        send_job(make_job(0, 0, 0, 0, 5, 60));
        send_job(make_job(16'hFFFF, 0, 0, 16'hFFFF, 1000000, 32'(TIME_TOP)));
        repeat (6) send_job(random_job());
    endtask

    initial begin
        int unsigned n_items;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        run_directed();
        for (int p = 0; p < NUM_PHASES; p++) begin
            drain();
            case (p / 3)
                0: begin
                    tx_idle_pct = 19;
                    rx_idle_pct = 80;
                end
                1: begin
                    tx_idle_pct = 80;
                    rx_idle_pct = 19;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            write_vehicle_count(CFG_W'(phase_counts[p]));
            n_items = (phase_counts[p] == 0) ? 40 : 230;
            repeat (n_items) send_job(random_job());
        end
        drain();
        $display("Summary: %0d jobs checked, %0d dispatched, over vehicle counts 0 to 127",
                 sb.jobs_seen, sb.jobs_taken);
        $display("Summary: %0d mismatched results, %0d results outstanding",
                 sb.mismatches, sb.expected_q.size());
        if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

/* files.f */
sv/fefd_pkg.sv
sv/fefd_eval.sv
sv/fleet_earliest_finish_dispatch.sv
sv/fefd_checker.sv
tb/fleet_earliest_finish_dispatch_tb.sv
